[rtl/pffl_pkg.sv]
// Package for the page-frame free-list allocator.
// Holds sizes, result status codes and the sequencer state type.
// No dependencies.
package pffl_pkg;

    localparam int NUM_FRAMES = 256;
    localparam int MAX_BURST  = 64;

    localparam int FRAME_W = $clog2(NUM_FRAMES);   // frame index width
    localparam int PTR_W   = FRAME_W + 1;          // frame index or end marker
    localparam int COUNT_W = 7;
    localparam int FREE_W  = 9;
    localparam int STAT_W  = 2;

    localparam logic [PTR_W-1:0] END_MARK = PTR_W'(NUM_FRAMES);

    localparam logic [STAT_W-1:0] ST_GIVEN    = 2'd0;
    localparam logic [STAT_W-1:0] ST_DONE     = 2'd1;
    localparam logic [STAT_W-1:0] ST_NO_ROOM  = 2'd2;
    localparam logic [STAT_W-1:0] ST_OVERFLOW = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FETCH,
        S_POP
    } state_t;

endpackage

[rtl/page_frame_free_list.sv]
// Top level of the page-frame free-list allocator.
// Depends on pffl_pkg and pffl_ram (the next-frame table).
//
// Usage
//   Requests arrive on the s_axis channel. s_axis_tuser is the mode: 0 asks
//   for count frames, 1 returns frame_in to the free list. Results leave on
//   the m_axis channel, one per allocated frame, or a single result for a
//   free, a zero count, a refused allocation or a dropped free; m_axis_tlast
//   marks the final result of each request.
//   One request is handled at a time. A free or any single-result request
//   has its result visible the cycle after acceptance. For an allocation,
//   each frame is first read from the next-frame table in S_FETCH
//   (registered read port); S_POP then emits the frame and advances the
//   head once the result register can take it.
//   A result register sits at the output; s_axis_tready is low while a
//   request is in progress or while the result register is full and not
//   being taken. When the receiver stalls, the sequencer holds in place.
//   Reset puts the list back to 0, 1, ..., N-1 at once: per-entry valid
//   bits are cleared, and an entry never written reads as its successor
//   index, so no clearing pass is needed.
module page_frame_free_list
    import pffl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // [6:0] count, [14:7] frame_in, [15] zero
    input  logic        s_axis_tuser,  // [0] mode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,  // [1:0] status, [9:2] frame_out,
                                       // [18:10] free_count, [23:19] zero
    output logic        m_axis_tlast
);

    state_t state_reg, state_next;

    logic [PTR_W-1:0]   head_reg, head_next;
    logic [FREE_W-1:0]  free_reg, free_next;
    logic [COUNT_W-1:0] remain_reg, remain_next;
    logic [NUM_FRAMES-1:0] valid_reg;
    logic               vld_q_reg;

    logic               out_valid_reg, out_valid_next;
    logic [STAT_W-1:0]  out_status_reg, out_status_next;
    logic [FRAME_W-1:0] out_frame_reg, out_frame_next;
    logic               out_last_reg, out_last_next;
    logic [FREE_W-1:0]  out_free_reg, out_free_next;

    logic               slot_free;
    logic               in_acc;
    logic               in_mode;
    logic [COUNT_W-1:0] in_count;
    logic [FRAME_W-1:0] in_frame;
    logic               alloc_bad;
    logic               free_bad;
    logic               head_live;
    logic [PTR_W-1:0]   succ;

    logic               ram_we;
    logic               ram_re;
    logic [PTR_W-1:0]   ram_rdata;

    assign slot_free     = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE) && slot_free;
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    assign in_mode  = s_axis_tuser;
    assign in_count = s_axis_tdata[COUNT_W-1:0];
    assign in_frame = s_axis_tdata[COUNT_W +: FRAME_W];

    assign alloc_bad = (in_count > COUNT_W'(MAX_BURST))
                    || ({{(FREE_W-COUNT_W){1'b0}}, in_count} > free_reg);
    assign free_bad  = (free_reg >= FREE_W'(NUM_FRAMES))
                    || ({1'b0, in_frame} >= PTR_W'(NUM_FRAMES));

    assign head_live = head_reg < END_MARK;
    // an entry never written holds its successor index
    assign succ = vld_q_reg ? ram_rdata : (head_reg + PTR_W'(1));

    pffl_ram #(
        .WIDTH (PTR_W),
        .DEPTH (NUM_FRAMES)
    ) u_next_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (in_frame),
        .wdata (head_reg),
        .re    (ram_re),
        .raddr (head_reg[FRAME_W-1:0]),
        .rdata (ram_rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc && !in_mode && (in_count != '0) && !alloc_bad)
                begin
                    state_next = S_FETCH;
                end
            end
            S_FETCH:
            begin
                state_next = S_POP;
            end
            S_POP:
            begin
                if (slot_free)
                begin
                    state_next = (remain_reg == COUNT_W'(1)) ? S_IDLE : S_FETCH;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        head_next       = head_reg;
        free_next       = free_reg;
        remain_next     = remain_reg;
        ram_we          = 1'b0;
        ram_re          = 1'b0;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_status_next = out_status_reg;
        out_frame_next  = out_frame_reg;
        out_last_next   = out_last_reg;
        out_free_next   = out_free_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    out_valid_next = 1'b1;
                    out_frame_next = '0;
                    out_last_next  = 1'b1;
                    out_free_next  = free_reg;
                    if (!in_mode)
                    begin
                        if (in_count == '0)
                        begin
                            out_status_next = ST_DONE;
                        end
                        else if (alloc_bad)
                        begin
                            out_status_next = ST_NO_ROOM;
                        end
                        else
                        begin
                            // no result yet: start walking the list
                            out_valid_next = 1'b0;
                            remain_next    = in_count;
                        end
                    end
                    else if (free_bad)
                    begin
                        out_status_next = ST_OVERFLOW;
                    end
                    else
                    begin
                        // push onto the head
                        ram_we          = 1'b1;
                        head_next       = {1'b0, in_frame};
                        free_next       = free_reg + FREE_W'(1);
                        out_status_next = ST_DONE;
                        out_free_next   = free_reg + FREE_W'(1);
                    end
                end
            end
            S_FETCH:
            begin
                ram_re = head_live;
            end
            S_POP:
            begin
                if (slot_free)
                begin
                    head_next       = head_live ? succ : END_MARK;
                    free_next       = free_reg - FREE_W'(1);
                    remain_next     = remain_reg - COUNT_W'(1);
                    out_valid_next  = 1'b1;
                    out_status_next = ST_GIVEN;
                    out_frame_next  = head_live ? head_reg[FRAME_W-1:0] : '0;
                    out_last_next   = (remain_reg == COUNT_W'(1));
                    out_free_next   = free_reg - FREE_W'(1);
                end
            end
            default:
            begin
                head_next = head_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            free_reg      <= FREE_W'(NUM_FRAMES);
            remain_reg    <= '0;
            valid_reg     <= '0;
            vld_q_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            free_reg      <= free_next;
            remain_reg    <= remain_next;
            out_valid_reg <= out_valid_next;
            if (ram_we)
            begin
                valid_reg[in_frame] <= 1'b1;
            end
            if (ram_re)
            begin
                vld_q_reg <= valid_reg[head_reg[FRAME_W-1:0]];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_status_reg <= out_status_next;
        out_frame_reg  <= out_frame_next;
        out_last_reg   <= out_last_next;
        out_free_reg   <= out_free_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {5'b0, out_free_reg, out_frame_reg, out_status_reg};

endmodule

[rtl/pffl_ram.sv]
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module pffl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[test/page_frame_free_list_test.sv]
// Self-checking testbench for page_frame_free_list: random and directed requests,
// results predicted from a shadow copy of the free list and checked field by field.
// Depends on pffl_pkg and the page_frame_free_list RTL.
module page_frame_free_list_test;
    import pffl_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    // Two copies of the list: one follows the DUT at acceptance, one plans stimulus
    localparam int MODEL = 0;
    localparam int PLAN  = 1;

    localparam int PHASE_ITEMS = 150;
    localparam int SETTLE      = 2 * MAX_BURST + 12;

    typedef struct packed {
        logic               mode;
        logic [COUNT_W-1:0] count;
        logic [FRAME_W-1:0] frame;
        logic               drain;    // hold back until all results are in
    } request_t;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [FRAME_W-1:0] frame;
        logic               last;
        logic [FREE_W-1:0]  free_cnt;
    } result_t;

    logic        clk;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata  = '0;  // [6:0] count, [14:7] frame_in, [15] zero
    logic        s_axis_tuser  = 1'b0; // [0] mode
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;        // [1:0] status, [9:2] frame_out,
                                      // [18:10] free_count, [23:19] zero
    logic        m_axis_tlast;

    logic [PTR_W-1:0]   link_tab [2][NUM_FRAMES];
    logic [PTR_W-1:0]   head_ptr [2];
    logic [FREE_W-1:0]  free_frames [2];

    request_t           queued_requests [$];
    result_t            due_results [$];
    logic [FRAME_W-1:0] held_frames [$];
    request_t           on_bus;
    result_t            got;
    result_t            want;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int requests_taken = 0;
    int results_seen = 0;
    int fail_count = 0;
    int status_seen [4] = '{0, 0, 0, 0};

    page_frame_free_list u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic void reset_list(int side);
        int i;
        for (i = 0; i < NUM_FRAMES; i++)
            link_tab[side][i] = PTR_W'(i + 1);
        head_ptr[side]    = '0;
        free_frames[side] = FREE_W'(NUM_FRAMES);
    endfunction

    function automatic void record(int side, logic [STAT_W-1:0] status,
                                   logic [FRAME_W-1:0] frame, logic last);
        result_t res;
        res.status   = status;
        res.frame    = frame;
        res.last     = last;
        res.free_cnt = free_frames[side];
        if (side == MODEL)
            due_results = {due_results, res};
        else if (status == ST_GIVEN)
            held_frames = {held_frames, frame};
    endfunction

    function automatic void apply_request(int side, request_t r);
        int k;
        logic [FRAME_W-1:0] given;
        if (r.mode == MODE_ALLOC)
        begin
            if (r.count == 0)
                record(side, ST_DONE, '0, 1'b1);
            else if (r.count > MAX_BURST || r.count > free_frames[side])
                record(side, ST_NO_ROOM, '0, 1'b1);
            else
            begin
                for (k = 0; k < r.count; k++)
                begin
                    given = '0;
                    // a broken list leaves the head parked on the end marker
                    if (head_ptr[side] < NUM_FRAMES)
                    begin
                        given = head_ptr[side][FRAME_W-1:0];
                        head_ptr[side] = link_tab[side][given];
                    end
                    else
                        head_ptr[side] = END_MARK;
                    free_frames[side] = free_frames[side] - 1'b1;
                    record(side, ST_GIVEN, given, k + 1 == r.count);
                end
            end
        end
        else if (free_frames[side] >= NUM_FRAMES || r.frame >= NUM_FRAMES)
            record(side, ST_OVERFLOW, '0, 1'b1);
        else
        begin
            // a double free is linked again, just as the hardware does
            link_tab[side][r.frame] = head_ptr[side];
            head_ptr[side] = {1'b0, r.frame};
            free_frames[side] = free_frames[side] + 1'b1;
            record(side, ST_DONE, '0, 1'b1);
        end
    endfunction

    function automatic void add_request(logic mode, int count, int frame, logic drain);
        request_t r;
        int i;
        r.mode  = mode;
        r.count = COUNT_W'(count);
        r.frame = FRAME_W'(frame);
        r.drain = drain;
        if (mode == MODE_FREE)
        begin
            for (i = held_frames.size() - 1; i >= 0; i--)
            begin
                if (held_frames[i] == r.frame)
                begin
                    held_frames.delete(i);
                    break;
                end
            end
        end
        apply_request(PLAN, r);
        queued_requests = {queued_requests, r};
    endfunction

    // Mostly legal allocations and returns of held frames, with some zero counts, refusals and stray frees mixed in
    function automatic void plan_random(logic allow_double, logic drain_now);
        int roll;
        int avail;
        int top;
        logic drain;
        roll  = $urandom_range(99);
        avail = free_frames[PLAN];
        drain = drain_now || ($urandom_range(59) == 0);
        if (roll < 3)
            add_request(MODE_ALLOC, 0, $urandom_range(255), drain);
        else if (roll < 6)
            add_request(MODE_ALLOC, $urandom_range(127, MAX_BURST + 1), 0, drain);
        else if (roll < 8 && avail < MAX_BURST)
            add_request(MODE_ALLOC, $urandom_range(MAX_BURST, avail + 1), 0, drain);
        else if ((roll < 10 && allow_double) || (held_frames.size() == 0 && avail == 0))
            add_request(MODE_FREE, 0, $urandom_range(255), drain);
        else if (held_frames.size() == 0 || (avail != 0 && roll < 55))
        begin
            top = ($urandom_range(9) == 0) ? MAX_BURST : 8;
            if (top > avail)
                top = avail;
            add_request(MODE_ALLOC, $urandom_range(top, 1), $urandom_range(255), drain);
        end
        else
            add_request(MODE_FREE, $urandom_range(127),
                        held_frames[$urandom_range(held_frames.size() - 1)], drain);
    endfunction

    task automatic wait_quiet();
        while (queued_requests.size() != 0 || s_axis_tvalid || due_results.size() != 0)
            @(negedge clk);
    endtask

    // Request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                apply_request(MODEL, on_bus);
                requests_taken++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (queued_requests.size() != 0 && $urandom_range(99) >= send_idle_pct
                    && !(queued_requests[0].drain && due_results.size() != 0))
                begin
                    on_bus = queued_requests.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {1'b0, on_bus.frame, on_bus.count};
                    s_axis_tuser  <= on_bus.mode;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Result monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.status   = m_axis_tdata[1:0];
                got.frame    = m_axis_tdata[9:2];
                got.free_cnt = m_axis_tdata[18:10];
                got.last     = m_axis_tlast;
                results_seen++;
                status_seen[got.status]++;
                if (due_results.size() == 0)
                begin
                    $error("unexpected result: status %0d frame_out %0d", got.status,
                           got.frame);
                    fail_count++;
                end
                else
                begin
                    want = due_results.pop_front();
                    if (got.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, got.status);
                        fail_count++;
                    end
                    if (got.frame !== want.frame)
                    begin
                        $error("frame_out: expected %0d, got %0d", want.frame, got.frame);
                        fail_count++;
                    end
                    if (got.last !== want.last)
                    begin
                        $error("last: expected %0d, got %0d", want.last, got.last);
                        fail_count++;
                    end
                    if (got.free_cnt !== want.free_cnt)
                    begin
                        $error("free_count: expected %0d, got %0d", want.free_cnt,
                               got.free_cnt);
                        fail_count++;
                    end
                end
            end
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        int phase;
        int n;
        reset_list(MODEL);
        reset_list(PLAN);
        while (!rst_n)
            @(negedge clk);

        send_idle_pct = 35;
        recv_idle_pct = 84;

        // full list, zero count, over-long bursts, running dry and refilling
        add_request(MODE_FREE, 0, 7, 1'b0);
        add_request(MODE_ALLOC, 0, 255, 1'b0);
        add_request(MODE_ALLOC, 127, 0, 1'b0);
        add_request(MODE_ALLOC, MAX_BURST + 1, 0, 1'b0);
        add_request(MODE_ALLOC, MAX_BURST, 0, 1'b0);
        add_request(MODE_ALLOC, 1, 0, 1'b0);
        add_request(MODE_FREE, 0, 0, 1'b0);
        add_request(MODE_ALLOC, 1, 0, 1'b0);
        add_request(MODE_ALLOC, MAX_BURST, 0, 1'b0);
        add_request(MODE_ALLOC, MAX_BURST, 0, 1'b0);
        add_request(MODE_ALLOC, MAX_BURST, 0, 1'b0);
        add_request(MODE_ALLOC, free_frames[PLAN], 0, 1'b0);
        add_request(MODE_ALLOC, 1, 0, 1'b0);
        add_request(MODE_FREE, 0, 255, 1'b0);
        add_request(MODE_FREE, 0, 0, 1'b0);
        add_request(MODE_ALLOC, 2, 0, 1'b0);
        add_request(MODE_FREE, 127, 128, 1'b0);
        add_request(MODE_FREE, 0, 64, 1'b0);
        add_request(MODE_FREE, 0, 170, 1'b1);
        add_request(MODE_FREE, 0, 85, 1'b0);

        for (phase = 0; phase < 3; phase++)
        begin
            if (phase == 1)
            begin
                send_idle_pct = 84;
                recv_idle_pct = 35;
            end
            else if (phase == 2)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            for (n = 0; n < PHASE_ITEMS; n++)
                plan_random(phase == 2, n == 0);
            wait_quiet();
        end

        repeat (SETTLE) @(negedge clk);
        $display("%0d requests taken, %0d results checked across three handshake phases",
                 requests_taken, results_seen);
        $display("%0d frames handed out, %0d plain completions, %0d refusals, %0d drops",
                 status_seen[ST_GIVEN], status_seen[ST_DONE], status_seen[ST_NO_ROOM],
                 status_seen[ST_OVERFLOW]);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
